/* design/mfb_pkg.sv */
`timescale 1ns / 1ps

package mfb_pkg;

   localparam int MAX_BINS         = 1024;
   localparam int MAX_FILTERS      = 64;
   localparam int WEIGHT_FRAC_BITS = 24;

   localparam int BIN_IDX_W    = $clog2(MAX_BINS);
   localparam int FILTER_IDX_W = $clog2(MAX_FILTERS);
   localparam int SEG_W        = 7;
   localparam int WEIGHT_W     = WEIGHT_FRAC_BITS;
   localparam int SAMPLE_W     = 24;
   localparam int PROD_W       = SAMPLE_W + WEIGHT_W;
   localparam int ENERGY_W     = 58;
   localparam int NF_W         = 7;
   localparam int NB_W         = 11;
   localparam int TAB_W        = SEG_W + 2 * WEIGHT_W;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = NB_W;

   localparam logic [NF_W-1:0] NUM_FILTERS_RESET = NF_W'(40);
   localparam logic [NB_W-1:0] NUM_BINS_RESET    = NB_W'(512);

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_FILTERS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BINS    = 1'b1;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAB,
      ST_UP,
      ST_DN,
      ST_DR_RD,
      ST_DR_WAIT
   } state_type;

   typedef struct packed {
      logic ready;
      logic tab;
      logic up;
      logic dn;
      logic dr_rd;
      logic dr_wait;
   } ctrl_type;

   typedef struct packed {
      logic fire_sample;
      logic frame_end;
      logic k_active;
      logic k_final;
      logic out_free;
   } stat_type;

   function automatic logic [ENERGY_W-1:0] sat_add(input logic [ENERGY_W-1:0] s,
                                                   input logic [PROD_W-1:0] p);
      logic [ENERGY_W:0] t;
      t = {1'b0, s} + (ENERGY_W + 1)'(p);
      return t[ENERGY_W] ? {ENERGY_W{1'b1}} : t[ENERGY_W-1:0];
   endfunction

endpackage

/* design/mfb_ram.sv */
`timescale 1ns / 1ps

module mfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/mfb_ctrl.sv */
`timescale 1ns / 1ps

module mfb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  mfb_pkg::stat_type stat,
   output mfb_pkg::ctrl_type ctrl
);

   mfb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mfb_pkg::ST_IDLE: begin
            if (stat.fire_sample) begin
               state_in = mfb_pkg::ST_TAB;
            end
         end
         mfb_pkg::ST_TAB: begin
            state_in = mfb_pkg::ST_UP;
         end
         mfb_pkg::ST_UP: begin
            state_in = mfb_pkg::ST_DN;
         end
         mfb_pkg::ST_DN: begin
            state_in = stat.frame_end ? mfb_pkg::ST_DR_RD : mfb_pkg::ST_IDLE;
         end
         mfb_pkg::ST_DR_RD: begin
            if (stat.k_active) begin
               state_in = mfb_pkg::ST_DR_WAIT;
            end else if (stat.k_final) begin
               state_in = mfb_pkg::ST_IDLE;
            end
         end
         mfb_pkg::ST_DR_WAIT: begin
            if (stat.out_free) begin
               state_in = stat.k_final ? mfb_pkg::ST_IDLE : mfb_pkg::ST_DR_RD;
            end
         end
         default: begin
            state_in = mfb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         mfb_pkg::ST_IDLE:    ctrl.ready   = 1'b1;
         mfb_pkg::ST_TAB:     ctrl.tab     = 1'b1;
         mfb_pkg::ST_UP:      ctrl.up      = 1'b1;
         mfb_pkg::ST_DN:      ctrl.dn      = 1'b1;
         mfb_pkg::ST_DR_RD:   ctrl.dr_rd   = 1'b1;
         mfb_pkg::ST_DR_WAIT: ctrl.dr_wait = 1'b1;
         default:             ctrl         = '0;
      endcase
   end

endmodule

/* design/mel_filter_bank_top.sv */
`timescale 1ns / 1ps
// Load item: written into the weight table at the accepting edge; the block stays ready for the next item.
// Sample item: table read, then up-edge and down-edge read-modify-write of the
// accumulator memory (one read and one write port); the next item waits for these steps.
// Frame end: after the last sample's steps, each filter in use is read and loaded into the result
// register, unused slots are stepped through up to MAX_FILTERS; input held off, rsp_ready low stalls.
// Reset: 40 filters / 512 bins, bin counter zero, accumulators zero via valid bits.

module mel_filter_bank_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_type,
   input  logic [mfb_pkg::BIN_IDX_W-1:0]          req_bin_index,
   input  logic [mfb_pkg::SEG_W-1:0]              req_segment_index,
   input  logic [mfb_pkg::WEIGHT_W-1:0]           req_up_weight,
   input  logic [mfb_pkg::WEIGHT_W-1:0]           req_down_weight,
   input  logic [mfb_pkg::SAMPLE_W-1:0]           req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [mfb_pkg::FILTER_IDX_W-1:0]       rsp_filter_index,
   output logic [mfb_pkg::ENERGY_W-1:0]           rsp_energy,
   output logic                                   rsp_last_filter,
   input  logic                                   csr_we,
   input  logic [mfb_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [mfb_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   mfb_pkg::ctrl_type ctrl;
   mfb_pkg::stat_type stat;

   logic [mfb_pkg::NF_W-1:0]         nf_raw_ff;
   logic [mfb_pkg::NB_W-1:0]         nb_raw_ff;
   logic [mfb_pkg::NF_W-1:0]         nf_clamp;
   logic [mfb_pkg::NB_W-1:0]         nb_clamp;

   logic [mfb_pkg::BIN_IDX_W-1:0]    bin_cnt_ff;
   logic [mfb_pkg::SAMPLE_W-1:0]     sample_ff;
   logic [mfb_pkg::NF_W-1:0]         nf_ff;
   logic                             frame_end_ff;
   logic                             frame_end_in;

   logic                             req_fire;
   logic                             tab_we;
   logic [mfb_pkg::TAB_W-1:0]        tab_rdata;
   logic [mfb_pkg::SEG_W-1:0]        tab_seg;
   logic [mfb_pkg::WEIGHT_W-1:0]     tab_up;
   logic [mfb_pkg::WEIGHT_W-1:0]     tab_dn;

   logic [mfb_pkg::SEG_W-1:0]        seg_ff;
   logic [mfb_pkg::SEG_W-1:0]        seg_m1;
   logic                             up_en_ff;
   logic                             dn_en_ff;
   logic [mfb_pkg::PROD_W-1:0]       up_prod_ff;
   logic [mfb_pkg::PROD_W-1:0]       dn_prod_ff;

   logic                             sum_we;
   logic [mfb_pkg::FILTER_IDX_W-1:0] sum_waddr;
   logic [mfb_pkg::ENERGY_W-1:0]     sum_wdata;
   logic                             sum_re;
   logic [mfb_pkg::FILTER_IDX_W-1:0] sum_raddr;
   logic [mfb_pkg::ENERGY_W-1:0]     sum_rdata;
   logic [mfb_pkg::ENERGY_W-1:0]     sum_rd;
   logic [mfb_pkg::MAX_FILTERS-1:0]  sum_vld_ff;
   logic [mfb_pkg::MAX_FILTERS-1:0]  sum_vld_in;
   logic                             rd_vld_ff;

   logic [mfb_pkg::FILTER_IDX_W-1:0] k_ff;
   logic                             out_load;

   logic                             rsp_valid_ff;
   logic [mfb_pkg::FILTER_IDX_W-1:0] rsp_idx_ff;
   logic [mfb_pkg::ENERGY_W-1:0]     rsp_energy_ff;
   logic                             rsp_last_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         nf_raw_ff <= mfb_pkg::NUM_FILTERS_RESET;
         nb_raw_ff <= mfb_pkg::NUM_BINS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mfb_pkg::CSR_NUM_FILTERS: nf_raw_ff <= csr_wdata[mfb_pkg::NF_W-1:0];
            mfb_pkg::CSR_NUM_BINS:    nb_raw_ff <= csr_wdata[mfb_pkg::NB_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      nf_clamp = nf_raw_ff;
      if (nf_raw_ff == '0) begin
         nf_clamp = mfb_pkg::NF_W'(1);
      end else if (nf_raw_ff > mfb_pkg::NF_W'(mfb_pkg::MAX_FILTERS)) begin
         nf_clamp = mfb_pkg::NF_W'(mfb_pkg::MAX_FILTERS);
      end
      nb_clamp = nb_raw_ff;
      if (nb_raw_ff < mfb_pkg::NB_W'(2)) begin
         nb_clamp = mfb_pkg::NB_W'(2);
      end else if (nb_raw_ff > mfb_pkg::NB_W'(mfb_pkg::MAX_BINS)) begin
         nb_clamp = mfb_pkg::NB_W'(mfb_pkg::MAX_BINS);
      end
   end

   // input side
   assign req_ready    = ctrl.ready;
   assign req_fire     = req_valid && ctrl.ready;
   assign tab_we       = req_fire && (req_type == mfb_pkg::REQ_LOAD);
   assign frame_end_in = (mfb_pkg::NB_W'(bin_cnt_ff) + mfb_pkg::NB_W'(1)) >= nb_clamp;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_cnt_ff   <= '0;
         frame_end_ff <= 1'b0;
      end else if (stat.fire_sample) begin
         bin_cnt_ff   <= frame_end_in ? '0 : bin_cnt_ff + mfb_pkg::BIN_IDX_W'(1);
         frame_end_ff <= frame_end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.fire_sample) begin
         sample_ff <= req_sample;
         nf_ff     <= nf_clamp;
      end
   end

   mfb_ram #(
      .WIDTH (mfb_pkg::TAB_W),
      .DEPTH (mfb_pkg::MAX_BINS)
   ) u_tab_ram (
      .clock (clock),
      .we    (tab_we),
      .waddr (req_bin_index),
      .wdata ({req_segment_index, req_up_weight, req_down_weight}),
      .re    (stat.fire_sample),
      .raddr (bin_cnt_ff),
      .rdata (tab_rdata)
   );

   assign tab_seg = tab_rdata[mfb_pkg::TAB_W-1 -: mfb_pkg::SEG_W];
   assign tab_up  = tab_rdata[2*mfb_pkg::WEIGHT_W-1 -: mfb_pkg::WEIGHT_W];
   assign tab_dn  = tab_rdata[mfb_pkg::WEIGHT_W-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.tab) begin
         seg_ff     <= tab_seg;
         up_en_ff   <= tab_seg < nf_ff;
         dn_en_ff   <= (tab_seg != '0) && ((tab_seg - mfb_pkg::SEG_W'(1)) < nf_ff);
         up_prod_ff <= mfb_pkg::PROD_W'(sample_ff) * mfb_pkg::PROD_W'(tab_up);
         dn_prod_ff <= mfb_pkg::PROD_W'(sample_ff) * mfb_pkg::PROD_W'(tab_dn);
      end
   end

   assign seg_m1 = seg_ff - mfb_pkg::SEG_W'(1);

   // accumulator memory access
   assign sum_rd = rd_vld_ff ? sum_rdata : '0;

   always_comb begin
      sum_we     = 1'b0;
      sum_waddr  = seg_ff[mfb_pkg::FILTER_IDX_W-1:0];
      sum_wdata  = '0;
      sum_re     = 1'b0;
      sum_raddr  = k_ff;
      sum_vld_in = sum_vld_ff;
      if (ctrl.tab) begin
         sum_re    = 1'b1;
         sum_raddr = tab_seg[mfb_pkg::FILTER_IDX_W-1:0];
      end
      if (ctrl.up) begin
         sum_we    = up_en_ff;
         sum_waddr = seg_ff[mfb_pkg::FILTER_IDX_W-1:0];
         sum_wdata = mfb_pkg::sat_add(sum_rd, up_prod_ff);
         sum_re    = 1'b1;
         sum_raddr = seg_m1[mfb_pkg::FILTER_IDX_W-1:0];
      end
      if (ctrl.dn) begin
         sum_we    = dn_en_ff;
         sum_waddr = seg_m1[mfb_pkg::FILTER_IDX_W-1:0];
         sum_wdata = mfb_pkg::sat_add(sum_rd, dn_prod_ff);
      end
      if (sum_we) begin
         sum_vld_in[sum_waddr] = 1'b1;
      end
      if (ctrl.dr_rd) begin
         sum_re           = stat.k_active;
         sum_raddr        = k_ff;
         sum_vld_in[k_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         sum_vld_ff <= sum_vld_in;
         if (sum_re) begin
            rd_vld_ff <= sum_vld_ff[sum_raddr];
         end
      end
   end

   mfb_ram #(
      .WIDTH (mfb_pkg::ENERGY_W),
      .DEPTH (mfb_pkg::MAX_FILTERS)
   ) u_sum_ram (
      .clock (clock),
      .we    (sum_we),
      .waddr (sum_waddr),
      .wdata (sum_wdata),
      .re    (sum_re),
      .raddr (sum_raddr),
      .rdata (sum_rdata)
   );

   // drain
   assign out_load = ctrl.dr_wait && stat.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (ctrl.dn) begin
         k_ff <= '0;
      end else if ((ctrl.dr_rd && !stat.k_active) || out_load) begin
         k_ff <= k_ff + mfb_pkg::FILTER_IDX_W'(1);
      end
   end

   always_comb begin
      stat.fire_sample = req_fire && (req_type == mfb_pkg::REQ_SAMPLE);
      stat.frame_end   = frame_end_ff;
      stat.k_active    = mfb_pkg::NF_W'(k_ff) < nf_ff;
      stat.k_final     = k_ff == mfb_pkg::FILTER_IDX_W'(mfb_pkg::MAX_FILTERS - 1);
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   mfb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_idx_ff    <= k_ff;
         rsp_energy_ff <= sum_rd;
         rsp_last_ff   <= (mfb_pkg::NF_W'(k_ff) + mfb_pkg::NF_W'(1)) == nf_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filter_index = rsp_idx_ff;
   assign rsp_energy       = rsp_energy_ff;
   assign rsp_last_filter  = rsp_last_ff;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int ITEM_TARGET   = 430;
   localparam int SETTLE_CYCLES = 3 * mfb_pkg::MAX_FILTERS + 16;
   localparam int RSP_HOLD      = 120;
   localparam int STALL_LIMIT   = 2000;
   localparam logic [63:0] ENERGY_SAT = (64'd1 << mfb_pkg::ENERGY_W) - 64'd1;

   typedef struct packed {
      logic                                kind;
      logic [mfb_pkg::BIN_IDX_W-1:0]       bin;
      logic [mfb_pkg::SEG_W-1:0]           seg;
      logic [mfb_pkg::WEIGHT_W-1:0]        up;
      logic [mfb_pkg::WEIGHT_W-1:0]        dn;
      logic [mfb_pkg::SAMPLE_W-1:0]        smp;
   } mel_req_type;

   typedef struct packed {
      logic [mfb_pkg::SEG_W-1:0]           seg;
      logic [mfb_pkg::WEIGHT_W-1:0]        up;
      logic [mfb_pkg::WEIGHT_W-1:0]        dn;
   } bin_weight_type;

   typedef struct packed {
      logic [mfb_pkg::FILTER_IDX_W-1:0]    filt;
      logic [mfb_pkg::ENERGY_W-1:0]        energy;
      logic                                last_f;
   } energy_rec_type;

   typedef enum logic [1:0] {ROW_REGS, ROW_LOAD, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      row_kind_type                        kind;
      logic [mfb_pkg::NB_W-1:0]            nf_raw;
      logic [mfb_pkg::NB_W-1:0]            nb_raw;
      logic [mfb_pkg::BIN_IDX_W-1:0]       bin;
      logic [mfb_pkg::SEG_W-1:0]           seg;
      logic [mfb_pkg::WEIGHT_W-1:0]        up;
      logic [mfb_pkg::WEIGHT_W-1:0]        dn;
      logic [mfb_pkg::SAMPLE_W-1:0]        smp;
      logic                                typed;
      logic [mfb_pkg::ENERGY_W-1:0]        energy;
   } dir_row_type;

   // typed energies apply to single-filter frames: filter 0, last set
   localparam int N_DIR = 24;
   dir_row_type dir_rows [N_DIR] = '{
      '{ROW_REGS,   11'd0,    11'd1,    10'd0,    7'd0,   24'd0,      24'd0,
        24'd0,      1'b0, 58'd0},
      '{ROW_LOAD,   11'd0,    11'd0,    10'd0,    7'd0,   24'hFFFFFF, 24'hFFFFFF,
        24'd0,      1'b0, 58'd0},
      '{ROW_LOAD,   11'd0,    11'd0,    10'd1,    7'd1,   24'hFFFFFF, 24'h000001,
        24'd0,      1'b0, 58'd0},
      '{ROW_SAMPLE, 11'd0,    11'd0,    10'd0,    7'd0,   24'd0,      24'd0,
        24'hFFFFFF, 1'b0, 58'd0},
      '{ROW_SAMPLE, 11'd0,    11'd0,    10'd0,    7'd0,   24'd0,      24'd0,
        24'h000002, 1'b1, 58'hFFFFFE000003},
      '{ROW_LOAD,   11'd0,    11'd0,    10'd0,    7'd5,   24'hFFFFFF, 24'hFFFFFF,
        24'd0,      1'b0, 58'd0},
      '{ROW_LOAD,   11'd0,    11'd0,    10'd1,    7'd0,   24'd0,      24'hFFFFFF,
        24'd0,      1'b0, 58'd0},
      '{ROW_SAMPLE, 11'd0,    11'd0,    10'd0,    7'd0,   24'd0,      24'd0,
        24'hFFFFFF, 1'b0, 58'd0},
      '{ROW_SAMPLE, 11'd0,    11'd0,    10'd0,    7'd0,   24'd0,      24'd0,
        24'hFFFFFF, 1'b1, 58'd0},
      '{ROW_LOAD,   11'd0,    11'd0,    10'd0,    7'd0,   24'hFFFFFF, 24'd0,
        24'd0,      1'b0, 58'd0},
      '{ROW_SAMPLE, 11'd0,    11'd0,    10'd0,    7'd0,   24'd0,      24'd0,
        24'd0,      1'b0, 58'd0},
      '{ROW_SAMPLE, 11'd0,    11'd0,    10'd0,    7'd0,   24'd0,      24'd0,
        24'd0,      1'b1, 58'd0},
      '{ROW_LOAD,   11'd0,    11'd0,    10'd1,    7'd0,   24'h000001, 24'd0,
        24'd0,      1'b0, 58'd0},
      '{ROW_SAMPLE, 11'd0,    11'd0,    10'd0,    7'd0,   24'd0,      24'd0,
        24'h000001, 1'b0, 58'd0},
      '{ROW_SAMPLE, 11'd0,    11'd0,    10'd0,    7'd0,   24'd0,      24'd0,
        24'h000001, 1'b1, 58'h1000000},
      // out-of-range register values clamp to 64 filters and 1024 bins
      '{ROW_REGS,   11'd2047, 11'd2047, 10'd0,    7'd0,   24'd0,      24'd0,
        24'd0,      1'b0, 58'd0},
      '{ROW_LOAD,   11'd0,    11'd0,    10'd1023, 7'd127, 24'hAAAAAA, 24'h555555,
        24'd0,      1'b0, 58'd0},
      '{ROW_LOAD,   11'd0,    11'd0,    10'd2,    7'd64,  24'h123456, 24'hFFFFFF,
        24'd0,      1'b0, 58'd0},
      '{ROW_SAMPLE, 11'd0,    11'd0,    10'd0,    7'd0,   24'd0,      24'd0,
        24'h0003FF, 1'b0, 58'd0},
      '{ROW_SAMPLE, 11'd0,    11'd0,    10'd0,    7'd0,   24'd0,      24'd0,
        24'h800000, 1'b0, 58'd0},
      '{ROW_SAMPLE, 11'd0,    11'd0,    10'd0,    7'd0,   24'd0,      24'd0,
        24'hFFFFFF, 1'b0, 58'd0},
      // shrinking the frame mid-way closes it on the next sample
      '{ROW_REGS,   11'd64,   11'd3,    10'd0,    7'd0,   24'd0,      24'd0,
        24'd0,      1'b0, 58'd0},
      '{ROW_LOAD,   11'd0,    11'd0,    10'd3,    7'd63,  24'hFFFFFF, 24'h7FFFFF,
        24'd0,      1'b0, 58'd0},
      '{ROW_SAMPLE, 11'd0,    11'd0,    10'd0,    7'd0,   24'd0,      24'd0,
        24'h00F0F0, 1'b0, 58'd0}
   };

   logic                                   clock;
   logic                                   reset             = 1'b1;
   logic                                   req_valid         = 1'b0;
   logic                                   req_ready;
   logic                                   req_type          = 1'b0;
   logic [mfb_pkg::BIN_IDX_W-1:0]          req_bin_index     = '0;
   logic [mfb_pkg::SEG_W-1:0]              req_segment_index = '0;
   logic [mfb_pkg::WEIGHT_W-1:0]           req_up_weight     = '0;
   logic [mfb_pkg::WEIGHT_W-1:0]           req_down_weight   = '0;
   logic [mfb_pkg::SAMPLE_W-1:0]           req_sample        = '0;
   logic                                   rsp_valid;
   logic                                   rsp_ready         = 1'b0;
   logic [mfb_pkg::FILTER_IDX_W-1:0]       rsp_filter_index;
   logic [mfb_pkg::ENERGY_W-1:0]           rsp_energy;
   logic                                   rsp_last_filter;
   logic                                   csr_we            = 1'b0;
   logic [mfb_pkg::CSR_IDX_W-1:0]          csr_index         = '0;
   logic [mfb_pkg::CSR_DATA_W-1:0]         csr_wdata         = '0;

   mel_filter_bank_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_bin_index     (req_bin_index),
      .req_segment_index (req_segment_index),
      .req_up_weight     (req_up_weight),
      .req_down_weight   (req_down_weight),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_filter_index  (rsp_filter_index),
      .rsp_energy        (rsp_energy),
      .rsp_last_filter   (rsp_last_filter),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // predictor state
   bin_weight_type                weight_tab [mfb_pkg::MAX_BINS];
   bit                            tab_loaded [mfb_pkg::MAX_BINS];
   logic [mfb_pkg::ENERGY_W-1:0]  filter_acc [mfb_pkg::MAX_FILTERS];
   int unsigned                   bin_pos = 0;
   logic [mfb_pkg::NF_W-1:0]      reg_nf  = mfb_pkg::NUM_FILTERS_RESET;
   logic [mfb_pkg::NB_W-1:0]      reg_nb  = mfb_pkg::NUM_BINS_RESET;

   energy_rec_type                pending_energies [$];

   bit                            calm     = 1'b0;
   bit                            hold_rsp = 1'b0;
   int                            errors     = 0;
   int                            items_sent = 0;
   int                            n_loads    = 0;
   int                            n_samples  = 0;
   int                            n_frames   = 0;
   int                            n_checked  = 0;
   int                            n_settings = 0;
   int                            idle_cycles = 0;

   logic                          got_fire = 1'b0;
   energy_rec_type                got_rec;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned filters_in_use();
      int unsigned v;
      v = reg_nf;
      if (v < 1) v = 1;
      if (v > mfb_pkg::MAX_FILTERS) v = mfb_pkg::MAX_FILTERS;
      return v;
   endfunction

   function automatic int unsigned bins_in_use();
      int unsigned v;
      v = reg_nb;
      if (v < 2) v = 2;
      if (v > mfb_pkg::MAX_BINS) v = mfb_pkg::MAX_BINS;
      return v;
   endfunction

   function automatic void acc_add(input int unsigned f, input logic [63:0] prod);
      logic [63:0] sum;
      if (f >= mfb_pkg::MAX_FILTERS) return;
      sum = 64'(filter_acc[f]) + prod;
      filter_acc[f] = (sum > ENERGY_SAT) ? ENERGY_SAT[mfb_pkg::ENERGY_W-1:0]
                                         : sum[mfb_pkg::ENERGY_W-1:0];
   endfunction

   function automatic void compute_filter_energies(input mel_req_type r,
                                                   ref energy_rec_type outq[$]);
      int unsigned nf, nb, sg;
      bin_weight_type ent;
      energy_rec_type rec;
      if (r.kind == mfb_pkg::REQ_LOAD) begin
         weight_tab[r.bin] = '{r.seg, r.up, r.dn};
         tab_loaded[r.bin] = 1'b1;
         return;
      end
      nf = filters_in_use();
      nb = bins_in_use();
      if (bin_pos >= mfb_pkg::MAX_BINS) bin_pos = 0;
      ent = weight_tab[bin_pos];
      sg = ent.seg;
      if (sg < nf) acc_add(sg, 64'(r.smp) * 64'(ent.up));
      if (sg >= 1 && sg - 1 < nf) acc_add(sg - 1, 64'(r.smp) * 64'(ent.dn));
      if (bin_pos + 1 >= nb) begin
         for (int k = 0; k < nf; k++) begin
            rec.filt   = k[mfb_pkg::FILTER_IDX_W-1:0];
            rec.energy = filter_acc[k];
            rec.last_f = (k + 1 == nf);
            outq.insert(outq.size(), rec);
         end
         for (int k = 0; k < mfb_pkg::MAX_FILTERS; k++) filter_acc[k] = '0;
         bin_pos = 0;
         n_frames++;
      end else begin
         bin_pos++;
      end
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      errors++;
   endtask

   task automatic check_energy(input energy_rec_type got);
      energy_rec_type want;
      if (pending_energies.size() == 0) begin
         report("unexpected result energy", 64'(got.energy), 64'd0);
         return;
      end
      want = pending_energies.pop_front();
      n_checked++;
      if (got.filt !== want.filt) report("filter_index", 64'(got.filt), 64'(want.filt));
      if (got.energy !== want.energy) report("energy", 64'(got.energy), 64'(want.energy));
      if (got.last_f !== want.last_f) report("last_filter", 64'(got.last_f), 64'(want.last_f));
   endtask

   // capture at the rising edge, compare at the falling edge
   always @(posedge clock) begin
      got_fire <= !reset && rsp_valid && rsp_ready;
      got_rec  <= {rsp_filter_index, rsp_energy, rsp_last_filter};
   end

   always @(negedge clock) begin
      if (got_fire) check_energy(got_rec);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("no item moved for %0d cycles", idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : rsp_side
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD) @(posedge clock);
         end
         stall = calm ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   function automatic logic [23:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 24'd0;
         1: return 24'hFFFFFF;
         default: return 24'($urandom_range(0, 32'hFFFFFF));
      endcase
   endfunction

   task automatic send_req(input mel_req_type r, input bit typed,
                           input logic [mfb_pkg::ENERGY_W-1:0] typed_energy);
      energy_rec_type got[$];
      energy_rec_type rec;
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= r.kind;
      req_bin_index     <= r.bin;
      req_segment_index <= r.seg;
      req_up_weight     <= r.up;
      req_down_weight   <= r.dn;
      req_sample        <= r.smp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      compute_filter_energies(r, got);
      if (typed) begin
         rec.filt   = '0;
         rec.energy = typed_energy;
         rec.last_f = 1'b1;
         pending_energies.insert(pending_energies.size(), rec);
      end else begin
         foreach (got[i]) pending_energies.insert(pending_energies.size(), got[i]);
      end
      items_sent++;
      if (r.kind == mfb_pkg::REQ_LOAD) n_loads++;
      else n_samples++;
   endtask

   task automatic send_load(input int unsigned bin, input logic [mfb_pkg::SEG_W-1:0] seg,
                            input logic [23:0] up, input logic [23:0] dn);
      mel_req_type r;
      r.kind = mfb_pkg::REQ_LOAD;
      r.bin  = bin[mfb_pkg::BIN_IDX_W-1:0];
      r.seg  = seg;
      r.up   = up;
      r.dn   = dn;
      r.smp  = 24'($urandom);
      send_req(r, 1'b0, '0);
   endtask

   task automatic send_sample(input logic [23:0] smp);
      mel_req_type r;
      int unsigned p;
      p = (bin_pos >= mfb_pkg::MAX_BINS) ? 0 : bin_pos;
      if (!tab_loaded[p])
         send_load(p, 7'($urandom_range(0, 127)), rand_word(), rand_word());
      if ($urandom_range(0, 9) == 0)
         send_load($urandom_range(0, mfb_pkg::MAX_BINS - 1), 7'($urandom_range(0, 127)),
                   rand_word(), rand_word());
      r.kind = mfb_pkg::REQ_SAMPLE;
      r.bin  = 10'($urandom);
      r.seg  = 7'($urandom);
      r.up   = 24'($urandom);
      r.dn   = 24'($urandom);
      r.smp  = smp;
      send_req(r, 1'b0, '0);
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_energies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_regs(input logic [mfb_pkg::NB_W-1:0] nf_raw,
                           input logic [mfb_pkg::NB_W-1:0] nb_raw);
      csr_we    <= 1'b1;
      csr_index <= mfb_pkg::CSR_NUM_FILTERS;
      csr_wdata <= nf_raw;
      @(posedge clock);
      reg_nf = nf_raw[mfb_pkg::NF_W-1:0];
      csr_index <= mfb_pkg::CSR_NUM_BINS;
      csr_wdata <= nb_raw;
      @(posedge clock);
      reg_nb = nb_raw;
      csr_we <= 1'b0;
      n_settings++;
   endtask

   task automatic run_phase(input logic [mfb_pkg::NB_W-1:0] nf_raw,
                            input logic [mfb_pkg::NB_W-1:0] nb_raw,
                            input int frames, input bit cut_short);
      int unsigned nfc, nbc, sg;
      int target, extra;
      drain_and_settle();
      set_regs(nf_raw, nb_raw);
      nfc = filters_in_use();
      nbc = bins_in_use();
      // ascending segments across the frame, with some stray entries
      for (int i = 0; i < nbc; i++) begin
         sg = (i * (nfc + 1)) / nbc;
         if ($urandom_range(0, 7) == 0) sg = $urandom_range(0, 127);
         send_load(i, sg[mfb_pkg::SEG_W-1:0], rand_word(), rand_word());
      end
      target = n_frames + frames;
      while (n_frames < target) send_sample(rand_word());
      if (cut_short) begin
         extra = $urandom_range(1, nbc - 1);
         repeat (extra) send_sample(rand_word());
      end
   endtask

   initial begin : stimulus
      mel_req_type r;
      logic [mfb_pkg::NB_W-1:0] nf_raw, nb_raw;
      foreach (tab_loaded[i]) tab_loaded[i] = 1'b0;
      foreach (filter_acc[i]) filter_acc[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_REGS) begin
            drain_and_settle();
            set_regs(dir_rows[i].nf_raw, dir_rows[i].nb_raw);
         end else begin
            r.kind = (dir_rows[i].kind == ROW_LOAD) ? mfb_pkg::REQ_LOAD : mfb_pkg::REQ_SAMPLE;
            r.bin  = dir_rows[i].bin;
            r.seg  = dir_rows[i].seg;
            r.up   = dir_rows[i].up;
            r.dn   = dir_rows[i].dn;
            r.smp  = dir_rows[i].smp;
            send_req(r, dir_rows[i].typed, dir_rows[i].energy);
         end
      end

      // receiver stalls long while the sender keeps pushing frames
      calm = 1'b1;
      hold_rsp = 1'b1;
      run_phase(11'd64, 11'd2, 6, 1'b0);

      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 5))
            0: nf_raw = 11'd1;
            1: nf_raw = 11'd64;
            2: nf_raw = 11'($urandom_range(0, 2047));
            default: nf_raw = 11'($urandom_range(1, 64) | ($urandom_range(0, 15) << 7));
         endcase
         case ($urandom_range(0, 5))
            0: nb_raw = 11'($urandom_range(0, 1));
            1: nb_raw = 11'd2;
            2: nb_raw = 11'($urandom_range(17, 48));
            default: nb_raw = 11'($urandom_range(3, 16));
         endcase
         calm = ($urandom_range(0, 3) == 0);
         run_phase(nf_raw, nb_raw, $urandom_range(1, 3), $urandom_range(0, 3) == 0);
      end

      drain_and_settle();
      $display("Sent %0d items (%0d table loads, %0d samples) over %0d register settings.",
               items_sent, n_loads, n_samples, n_settings);
      $display("Checked %0d filter energies from %0d frames, %0d mismatches.",
               n_checked, n_frames, errors);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
